FILE: rtl/rtkl_pkg.sv
// Package for the record table key lookup block: sizes, codes, record type
// and helpers. Depends on nothing; the cell, the top module and the testbench import it.
`timescale 1ns / 1ps
package rtkl_pkg;

  // Number of records the table can hold.
  localparam int CAPACITY = 10;
  // Width of the record count and of the walk step counter.
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0] CAP_CNT   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CAPACITY - 1);

  // Command codes.
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;
  localparam logic [1:0] CMD_SHOW   = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [63:0] name;
    logic [7:0]  age;
  } record_t;

  // Fits a record count into the four-bit entry_total field.
  function automatic logic [3:0] to_total(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+3:0] wide;
    wide = {4'b0000, cnt};
    return wide[3:0];
  endfunction

endpackage

FILE: rtl/rtkl_in_if.sv
// Command channel interface of the record table: valid, ready and one
// command word. Depends on nothing.
`timescale 1ns / 1ps
interface rtkl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] key_name;
  logic [7:0]  age_value;

  modport source (output valid, output command, output key_name, output age_value,
                  input ready);
  modport sink (input valid, input command, input key_name, input age_value,
                output ready);
endinterface

FILE: rtl/rtkl_out_if.sv
// Result channel interface of the record table: valid, ready and one
// result word. Depends on nothing.
`timescale 1ns / 1ps
interface rtkl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] record_name;
  logic [7:0]  record_age;
  logic [3:0]  entry_total;
  logic        last_result;

  modport source (output valid, output status, output record_name, output record_age,
                  output entry_total, output last_result, input ready);
  modport sink (input valid, input status, input record_name, input record_age,
                input entry_total, input last_result, output ready);
endinterface

FILE: rtl/rtkl_cell.sv
// One storage cell of the record ring: holds a single record and takes its
// neighbor's record on every shift. Depends on rtkl_pkg.
`timescale 1ns / 1ps
module rtkl_cell
  import rtkl_pkg::*;
(
  input  logic    clk,
  input  logic    shift_en,
  input  record_t rec_in,
  output record_t rec_out
);

  record_t rec_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

FILE: rtl/record_table_key_lookup.sv
// Record table key lookup: a table of up to CAPACITY records (64-bit name
// key, 8-bit age) that takes add, remove, search and show commands.
// Depends on rtkl_pkg, rtkl_in_if, rtkl_out_if and rtkl_cell.
//
// Use: a command word enters on in_ch when valid and ready are both high;
// ready is high only while no command is being worked on. Every command
// walks the record ring once, CAPACITY steps, and the next command is
// accepted only after the walk ends. The walk length is set by the ring
// of cells: each cycle in which the ring shifts, every cell passes its
// record toward the head, and one full turn brings the table back in order.
// Add, remove and search give one result word at the last step of the
// walk. Show gives one word per stored record as the walk reaches it, the
// final one marked by last_result, or a single empty-status word.
// Results sit in an output register; while the receiver holds ready low the
// ring freezes at any step that has a word to deliver, so nothing is lost.
// A command can be accepted while the last result word of the previous one
// still waits in the output register.
// Reset clears the record count and the control state; the stored records
// are not cleared, since entries at or above the count are never reported.
`timescale 1ns / 1ps
module record_table_key_lookup
  import rtkl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rtkl_in_if.sink    in_ch,
  rtkl_out_if.source out_ch
);

  // Controller states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       cmd_r;
  record_t          key_rec_r;   // Key and age of the command being worked on.
  logic             found_r, found_nxt;
  record_t          hit_rec_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  record_t          out_rec_r;
  logic [3:0]       out_total_r;
  logic             out_last_r;

  record_t          cell_rec [CAPACITY];
  record_t          head_rec;
  record_t          next_rec;
  record_t          feed_rec;

  logic             in_fire;
  logic             walking;
  logic             in_range;
  logic             hit_now;
  logic             found_any;
  logic             is_show_list;
  logic             last_step;
  logic             emit;
  logic             out_free;
  logic             shift_go;
  logic [CNT_W-1:0] step_inc;
  logic [1:0]       fin_status;
  record_t          fin_rec;
  logic [CNT_W-1:0] fin_count;

  assign walking  = (state_r == S_WALK);
  assign in_ch.ready = !walking;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // The head cell holds the record whose original index equals the step;
  // the cell behind it holds the following record.
  assign head_rec = cell_rec[0];
  generate
    if (CAPACITY > 1) begin : g_next
      assign next_rec = cell_rec[1];
    end else begin : g_next_one
      assign next_rec = cell_rec[0];
    end
  endgenerate

  assign step_inc  = step_r + CNT_W'(1);
  assign last_step = (step_r == LAST_STEP);
  assign in_range  = (step_r < count_r);

  // First exact key match among stored records.
  assign hit_now   = walking && in_range && !found_r && (head_rec.name == key_rec_r.name)
                     && ((cmd_r == CMD_REMOVE) || (cmd_r == CMD_SEARCH));
  assign found_any = found_r || hit_now;

  // Show on a non-empty table reports each stored record in turn; all other
  // cases report once at the end of the walk.
  assign is_show_list = (cmd_r == CMD_SHOW) && (count_r != '0);
  assign emit     = walking && (is_show_list ? in_range : last_step);
  assign shift_go = walking && (!emit || out_free);

  // Record that goes into the tail cell. A plain turn feeds the head back.
  // Add drops the new record in at the slot equal to the count. Remove,
  // from the matching record onward, feeds the following record instead,
  // which closes the gap and keeps the order.
  always_comb begin
    feed_rec = head_rec;
    unique case (cmd_r)
      CMD_ADD: begin
        if ((step_r == count_r) && (count_r != CAP_CNT)) begin
          feed_rec = key_rec_r;
        end
      end
      CMD_REMOVE: begin
        if (found_any) begin
          feed_rec = next_rec;
        end
      end
      default: begin
        feed_rec = head_rec;
      end
    endcase
  end

  // The ring of cells.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      record_t link_in;
      if (i == CAPACITY - 1) begin : g_tail
        assign link_in = feed_rec;
      end else begin : g_body
        assign link_in = cell_rec[i+1];
      end
      rtkl_cell u_cell (
        .clk      (clk),
        .shift_en (shift_go),
        .rec_in   (link_in),
        .rec_out  (cell_rec[i])
      );
    end
  endgenerate

  // Final word of a single-result command and the count it leaves behind.
  always_comb begin
    fin_status = STAT_OK;
    fin_rec    = '0;
    fin_count  = count_r;
    unique case (cmd_r)
      CMD_ADD: begin
        if (count_r == CAP_CNT) begin
          fin_status = STAT_FULL;
        end else begin
          fin_count = count_r + CNT_W'(1);
        end
      end
      CMD_REMOVE, CMD_SEARCH: begin
        if (count_r == '0) begin
          fin_status = STAT_EMPTY;
        end else if (!found_any) begin
          fin_status = STAT_NOTFOUND;
        end else begin
          fin_rec = found_r ? hit_rec_r : head_rec;
          if (cmd_r == CMD_REMOVE) begin
            fin_count = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        fin_status = STAT_EMPTY;
      end
    endcase
  end

  // Controller.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    found_nxt = found_r;
    if (!walking) begin
      if (in_fire) begin
        state_nxt = S_WALK;
        step_nxt  = '0;
        found_nxt = 1'b0;
      end
    end else if (shift_go) begin
      if (hit_now) begin
        found_nxt = 1'b1;
      end
      if (last_step) begin
        state_nxt = S_IDLE;
        count_nxt = is_show_list ? count_r : fin_count;
      end else begin
        step_nxt = step_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      count_r <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r          <= in_ch.command;
      key_rec_r.name <= in_ch.key_name;
      key_rec_r.age  <= in_ch.age_value;
    end
    if (hit_now && shift_go) begin
      hit_rec_r <= head_rec;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && out_free) begin
      if (is_show_list) begin
        out_status_r <= STAT_OK;
        out_rec_r    <= head_rec;
        out_total_r  <= to_total(count_r);
        out_last_r   <= (step_inc == count_r);
      end else begin
        out_status_r <= fin_status;
        out_rec_r    <= fin_rec;
        out_total_r  <= to_total(fin_count);
        out_last_r   <= 1'b1;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.record_name = out_rec_r.name;
  assign out_ch.record_age  = out_rec_r.age;
  assign out_ch.entry_total = out_total_r;
  assign out_ch.last_result = out_last_r;

endmodule

FILE: tb/tb_record_table_key_lookup.sv
// Self-checking testbench for record_table_key_lookup: a shadow copy of the record
// table predicts every result word, which is checked in order against the block.
// Depends on rtkl_pkg, rtkl_in_if, rtkl_out_if and the block itself.
`timescale 1ns / 1ps
module tb_record_table_key_lookup;
  import rtkl_pkg::*;

  // One expected word on the result channel.
  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] name;
    logic [7:0]  age;
    logic [3:0]  total;
    logic        last;
  } result_word_t;

  // The slowest correct run is roughly 180 items, each with up to ten result
  // words that can each wait out a receiver stall, plus sender gaps and the
  // walk. The limit is set well above that.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the long receiver hold-off used to fill the block up.
  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;

  rtkl_in_if  in_ch ();
  rtkl_out_if out_ch ();

  record_table_key_lookup DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the table. Only entries below shadow_count are ever read.
  logic [63:0]  shadow_name [CAPACITY];
  logic [7:0]   shadow_age  [CAPACITY];
  int           shadow_count;

  // Words that the block still owes us, oldest first.
  result_word_t pending_words [$];
  int           mismatch_count;

  // Idling controls. The sender and the receiver each idle in random bursts
  // while their flag is set. hold_req asks the receiver for one long hold-off.
  bit           send_idle_on;
  bit           stall_on;
  int           hold_req;

  // A few fixed keys. They are reused often, so that searches and removes
  // hit, and so that the table ends up holding duplicate keys.
  logic [63:0]  key_pool [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run watchdog. If the run is still going after the limit, something hung.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Applies one accepted command to the shadow table and queues the words
  // that it must produce. Remove and search act on the first exact match.
  // Show lists every stored record in order and marks the final one.
  function void table_command(input logic [1:0] cmd, input logic [63:0] key,
                              input logic [7:0] age);
    int           pos;
    result_word_t w;
    pos    = -1;
    w      = '0;
    w.last = 1'b1;
    case (cmd)
      CMD_ADD: begin
        if (shadow_count >= CAPACITY) begin
          w.status = STAT_FULL;
        end else begin
          shadow_name[shadow_count] = key;
          shadow_age[shadow_count]  = age;
          shadow_count++;
          w.status = STAT_OK;
        end
        w.total = 4'(shadow_count);
        pending_words.push_back(w);
      end
      CMD_REMOVE, CMD_SEARCH: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (pos < 0 && shadow_name[i] === key) pos = i;
        end
        if (shadow_count == 0) begin
          w.status = STAT_EMPTY;
        end else if (pos < 0) begin
          w.status = STAT_NOTFOUND;
        end else begin
          w.status = STAT_OK;
          w.name   = shadow_name[pos];
          w.age    = shadow_age[pos];
          if (cmd == CMD_REMOVE) begin
            // Later records move down one place and keep their order.
            for (int i = pos; i + 1 < shadow_count; i++) begin
              shadow_name[i] = shadow_name[i + 1];
              shadow_age[i]  = shadow_age[i + 1];
            end
            shadow_count--;
          end
        end
        w.total = 4'(shadow_count);
        pending_words.push_back(w);
      end
      default: begin
        if (shadow_count == 0) begin
          w.status = STAT_EMPTY;
          pending_words.push_back(w);
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            w.status = STAT_OK;
            w.name   = shadow_name[i];
            w.age    = shadow_age[i];
            w.total  = 4'(shadow_count);
            w.last   = (i == shadow_count - 1);
            pending_words.push_back(w);
          end
        end
      end
    endcase
  endfunction

  function void check_field(input string field, input logic [63:0] want,
                            input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endfunction

  // Result checker. A word moves when valid and ready are both high at a
  // rising edge; it is compared field by field with the oldest expectation.
  always @(posedge clk) begin : word_check
    result_word_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        $display({"%0t: unexpected result word, expected none, actual status %0h",
                  " name %0h age %0h total %0h last %0b"},
                 $time, out_ch.status, out_ch.record_name, out_ch.record_age,
                 out_ch.entry_total, out_ch.last_result);
      end else begin
        want = pending_words.pop_front();
        check_field("status",      64'(want.status), 64'(out_ch.status));
        check_field("record_name", want.name,        out_ch.record_name);
        check_field("record_age",  64'(want.age),    64'(out_ch.record_age));
        check_field("entry_total", 64'(want.total),  64'(out_ch.entry_total));
        check_field("last_result", 64'(want.last),   64'(out_ch.last_result));
      end
    end
  end

  // Receiver. Ready changes only at falling edges. A hold-off request is
  // taken over here and counted down in cycles, independent of the sender.
  initial begin : result_sink
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req   = 0;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Sends one command word. Called at a falling edge and returns at the
  // falling edge after acceptance with valid still high, so that back-to-back
  // words keep valid asserted without a drop in between.
  task automatic send_cmd(input logic [1:0] cmd, input logic [63:0] key,
                          input logic [7:0] age);
    int gap;
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 18);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.command   <= cmd;
    in_ch.key_name  <= key;
    in_ch.age_value <= age;
    in_ch.valid     <= 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    table_command(cmd, key, age);
    @(negedge clk);
  endtask

  // Drops valid and waits until every expected word has come back.
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
  endtask

  // Mostly keys that the table holds or a pool key, sometimes a fully
  // random one, so that hits, misses and duplicates all happen.
  function logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < 55) return shadow_name[$urandom_range(0, shadow_count - 1)];
    if (r < 80) return key_pool[$urandom_range(0, 3)];
    return {$urandom, $urandom};
  endfunction

  // One random command. The bias steers the table toward full (0), toward
  // empty (1) or keeps it mixed (2), so both boundaries are reached often.
  task automatic send_random_cmd(input int bias);
    int         r;
    logic [1:0] cmd;
    r = $urandom_range(0, 99);
    case (bias)
      0:       cmd = (r < 55) ? CMD_ADD : (r < 70) ? CMD_REMOVE : (r < 88) ? CMD_SEARCH : CMD_SHOW;
      1:       cmd = (r < 20) ? CMD_ADD : (r < 65) ? CMD_REMOVE : (r < 85) ? CMD_SEARCH : CMD_SHOW;
      default: cmd = (r < 35) ? CMD_ADD : (r < 60) ? CMD_REMOVE : (r < 85) ? CMD_SEARCH : CMD_SHOW;
    endcase
    send_cmd(cmd, pick_key(), 8'($urandom));
  endtask

  // Every command on an empty table: show gives one empty word, remove and
  // search report an empty table.
  task automatic test_empty_table();
    send_cmd(CMD_SHOW,   64'h0,       8'h00);
    send_cmd(CMD_REMOVE, key_pool[2], 8'h00);
    send_cmd(CMD_SEARCH, 64'h0,       8'h00);
    wait_drain();
  endtask

  // The all-zero key is an ordinary key. The all-ones key and the largest
  // age check the top bits. Missing keys must report not found.
  task automatic test_zero_and_max_keys();
    send_cmd(CMD_ADD,    64'h0,                 8'h00);
    send_cmd(CMD_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    send_cmd(CMD_SEARCH, 64'h0,                 8'h5A);
    send_cmd(CMD_SEARCH, 64'h0000_0000_0000_0001, 8'h00);
    send_cmd(CMD_REMOVE, key_pool[2],           8'h00);
    wait_drain();
  endtask

  // Fill the table, with a second zero key in it, then add once more on a
  // full table. Show lists all ten records, and search must find the first
  // of the two zero keys.
  task automatic test_full_table();
    for (int i = 0; i < 8; i++) begin
      send_cmd(CMD_ADD, (i == 3) ? 64'h0 : {$urandom, $urandom}, 8'($urandom));
    end
    send_cmd(CMD_ADD,    64'hAAAA_5555_AAAA_5555, 8'h81);
    send_cmd(CMD_SHOW,   64'h0,                 8'h00);
    send_cmd(CMD_SEARCH, 64'h0,                 8'h00);
    wait_drain();
  endtask

  // Removal at the front, at the end and in the middle. The closing show
  // confirms that the remaining records kept their order.
  task automatic test_remove_order();
    send_cmd(CMD_REMOVE, 64'h0,                            8'h00);
    send_cmd(CMD_REMOVE, shadow_name[shadow_count - 1],    8'h00);
    send_cmd(CMD_REMOVE, shadow_name[2],                   8'h00);
    send_cmd(CMD_SHOW,   64'h0,                            8'h00);
    wait_drain();
  endtask

  // The receiver holds ready low for a long stretch while shows and adds
  // keep coming. The output register fills, the walk freezes, and the input
  // must stall until the receiver lets go.
  task automatic test_output_hold();
    hold_req = HOLD_CYCLES;
    send_cmd(CMD_ADD,  key_pool[1], 8'h11);
    send_cmd(CMD_ADD,  key_pool[3], 8'h22);
    repeat (4) send_cmd(CMD_SHOW, 64'h0, 8'h00);
    wait_drain();
  endtask

  // Random commands in blocks of sixteen. Each block has its own bias and its
  // own idling pattern, so some stretches run without any gaps at all.
  task automatic test_random_mix();
    for (int blk = 0; blk < 8; blk++) begin
      send_idle_on = (blk % 4) != 3;
      stall_on     = (blk % 3) != 2;
      repeat (16) send_random_cmd(blk % 3);
    end
    wait_drain();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_final_no_idle();
    send_idle_on = 1'b0;
    stall_on     = 1'b0;
    repeat (24) send_random_cmd(2);
    wait_drain();
  endtask

  initial begin
    key_pool[0] = 64'h0;
    key_pool[1] = 64'h414C_4943_4500_0000;
    key_pool[2] = 64'h424F_4200_0000_0000;
    key_pool[3] = 64'hFFFF_FFFF_FFFF_FFFF;

    shadow_count   = 0;
    mismatch_count = 0;
    hold_req       = 0;
    send_idle_on   = 1'b1;
    stall_on       = 1'b1;

    // All block inputs start at known values.
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.command   = CMD_ADD;
    in_ch.key_name  = 64'h0;
    in_ch.age_value = 8'h00;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_zero_and_max_keys();
    test_full_table();
    test_remove_order();
    test_output_hold();
    test_random_mix();
    test_final_no_idle();

    // Any stray word after the last expected one would show up in this window.
    repeat (3 * CAPACITY) @(posedge clk);
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/rtkl_pkg.sv
rtl/rtkl_in_if.sv
rtl/rtkl_out_if.sv
rtl/rtkl_cell.sv
rtl/record_table_key_lookup.sv
tb/tb_record_table_key_lookup.sv
